FILE: sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg - shared definitions of the modular exponentiation block
// arithmetic width, sequencer states and the multiplier status group
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  // width of the ports of every field
  localparam int unsigned DataW = 32;

  // arithmetic width: operands and modulus are taken in their low WIDTH bits
  localparam int unsigned WIDTH = 32;

  // bit counter of the serial multiplier
  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  localparam logic [DataW-1:0] ModulusRst = DataW'(23);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MULR,
    ST_SQR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

`default_nettype wire

FILE: sv/modexp_mul.sv
// ----------------------------------------------------------------------------
// modexp_mul - bit-serial modular multiplier
// one bit of the first operand per cycle, msb first, by doubling and adding
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [modexp_pkg::WIDTH-1:0] a_i,
  input  wire logic [modexp_pkg::WIDTH-1:0] b_i,
  input  wire logic [modexp_pkg::WIDTH-1:0] m_i,
  output logic      [modexp_pkg::WIDTH-1:0] prod_o,
  output modexp_pkg::mul_sts_t              sts_o
);
  import modexp_pkg::*;

  logic [WIDTH-1:0] a_sr_q, a_sr_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] step;

  // (x + y) mod m for x, y below m; a zero modulus wraps at 2^WIDTH
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if ((m != '0) && (s >= {1'b0, m})) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  always_comb begin
    dbl  = add_mod(acc_q, acc_q, m_q);
    step = a_sr_q[WIDTH-1] ? add_mod(dbl, b_q, m_q) : dbl;
  end

  always_comb begin
    a_sr_d = a_sr_q;
    b_d    = b_q;
    m_d    = m_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_sr_d = a_i;
      b_d    = b_i;
      m_d    = m_i;
      acc_d  = '0;
      cnt_d  = CntLast;
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_sr_d = {a_sr_q[WIDTH-2:0], 1'b0};
      acc_d  = step;
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sr_q <= a_sr_d;
    b_q    <= b_d;
    m_q    <= m_d;
    acc_q  <= acc_d;
  end

  assign prod_o     = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

FILE: sv/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top - base to the power exponent modulo modulus
// right-to-left square-and-multiply over one bit-serial modular multiplier
// ----------------------------------------------------------------------------
// usage:
//   cfg channel (cfg_valid_i / cfg_ready_o, modulus_i) writes the modulus;
//   always ready, write it only while no transaction is in flight. reset
//   value of the modulus is 23.
//   in channel (in_valid_i / in_ready_o) carries base_value_i and exponent_i;
//   one transaction is worked on at a time, in_ready_o is high when idle.
//   out channel (out_valid_o / out_ready_i) carries power_result_o from an
//   output register, so the next input is taken while a result waits.
// sequence:
//   every modular product runs through the serial multiplier one operand
//   bit per cycle. the base is first reduced by one product, then
//   each exponent bit up to the highest set one costs a pass through the
//   check state, one squaring and, for a one bit, one more product. the
//   input reopens in the same cycle as the result appears.
// reset clears the sequencer, the output valid and restores the modulus.
// if the receiver stalls, a finished result holds in the output register
// and a following transaction waits at its end until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [modexp_pkg::DataW-1:0] modulus_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [modexp_pkg::DataW-1:0] base_value_i,
  input  wire logic [modexp_pkg::DataW-1:0] exponent_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [modexp_pkg::DataW-1:0] power_result_o
);
  import modexp_pkg::*;

  state_e           state_q, state_d;
  logic [DataW-1:0] modulus_q;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] result_q, result_d;

  logic             mul_start;
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [WIDTH-1:0] mul_prod;
  mul_sts_t         mul_sts;
  logic             out_free;

  modexp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (WIDTH'(modulus_q)),
    .prod_o (mul_prod),
    .sts_o  (mul_sts)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_REDUCE;
      ST_REDUCE: if (mul_sts.done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (exp_q == '0) begin
          state_d = ST_FINISH;
        end else if (exp_q[0]) begin
          state_d = ST_MULR;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_MULR:   if (mul_sts.done) state_d = ST_SQR;
      ST_SQR:    if (mul_sts.done) state_d = ST_CHECK;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mul_start   = 1'b0;
    mul_a       = base_q;
    mul_b       = base_q;
    base_d      = base_q;
    exp_d       = exp_q;
    r_d         = r_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // base mod modulus as a product with one
          mul_start = 1'b1;
          mul_a     = WIDTH'(base_value_i);
          mul_b     = WIDTH'(1);
          exp_d     = WIDTH'(exponent_i);
          r_d       = WIDTH'(1);
        end
      end
      ST_REDUCE: begin
        if (mul_sts.done) base_d = mul_prod;
      end
      ST_CHECK: begin
        if (exp_q != '0) begin
          mul_start = 1'b1;
          if (exp_q[0]) mul_a = r_q;
        end
      end
      ST_MULR: begin
        if (mul_sts.done) begin
          r_d       = mul_prod;
          mul_start = 1'b1;
        end
      end
      ST_SQR: begin
        if (mul_sts.done) begin
          base_d = mul_prod;
          exp_d  = {1'b0, exp_q[WIDTH-1:1]};
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          result_d    = DataW'(r_q);
          out_valid_d = 1'b1;
        end
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= ModulusRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) modulus_q <= modulus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    exp_q    <= exp_d;
    r_q      <= r_d;
    result_q <= result_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

endmodule

`default_nettype wire

FILE: sv/modexp_checker.sv
// ----------------------------------------------------------------------------
// modexp_checker - port-level checks of the modular exponentiation block
// one transaction in flight, result ordering against input acceptance
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o,
  input wire logic [modexp_pkg::DataW-1:0] modulus_i,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [modexp_pkg::DataW-1:0] base_value_i,
  input wire logic [modexp_pkg::DataW-1:0] exponent_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [modexp_pkg::DataW-1:0] power_result_o
);

  logic unused_bits;
  assign unused_bits = cfg_valid_i ^ (^modulus_i) ^ (^base_value_i) ^ (^exponent_i);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(power_result_o))
    else $error("result changed or dropped while stalled");

  // only one transaction at work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transaction");

  // a new result comes only at the end of work, with the block back to idle
  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && $past(!in_ready_o))
    else $error("result appeared outside the end of a transaction");

  // the modulus write channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (.*);

`default_nettype wire

FILE: bench/modular_exponentiation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top_tb - checks base^exponent mod modulus
// operand pairs go in over the input channel and each power_result is compared
// with a square-and-multiply predictor that uses double-width products. the
// run walks the modulus through its extremes and random values, under random
// idling of both channels and a long hold-off of the result channel.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;
  import modexp_pkg::*;

  localparam int unsigned HalfPeriod = 4;
  localparam logic [DataW-1:0] AllOnes = '1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [DataW-1:0] modulus_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] base_value_i = '0;
  logic [DataW-1:0] exponent_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] power_result_o;

  logic [DataW-1:0] power_q[$];
  logic [DataW-1:0] modulus_now = ModulusRst;
  logic [DataW-1:0] want_power;
  int unsigned      error_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      hold_left = 0;

  modular_exponentiation_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .modulus_i     (modulus_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .power_result_o(power_result_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // a * b mod m with an exact double-width product; m of zero wraps
  function automatic logic [DataW-1:0] mod_product(input logic [DataW-1:0] a, b, m);
    logic [2*DataW-1:0] prod;
    prod = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
    if (m == '0) return prod[DataW-1:0];
    return DataW'(prod % {{DataW{1'b0}}, m});
  endfunction

  function automatic logic [DataW-1:0] modular_power(input logic [DataW-1:0] base, expo, m);
    logic [DataW-1:0] acc;
    logic [DataW-1:0] sq;
    logic [DataW-1:0] rest;
    acc = DataW'(1);
    sq = (m != '0) ? base % m : base;
    rest = expo;
    while (rest != '0) begin
      if (rest[0]) acc = mod_product(acc, sq, m);
      sq = mod_product(sq, sq, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  // mostly short exponents to keep the run short, some full width
  function automatic logic [DataW-1:0] rand_exponent();
    int unsigned pick;
    int unsigned len;
    logic [DataW-1:0] mask;
    pick = $urandom_range(9);
    len = $urandom_range(12);
    mask = DataW'((64'd1 << len) - 1);
    if (pick <= 6) return $urandom & mask;
    if (pick <= 8) return $urandom;
    return (len[0]) ? '0 : DataW'(1) << $urandom_range(DataW - 1);
  endfunction

  function automatic logic [DataW-1:0] rand_base(input logic [DataW-1:0] m);
    case ($urandom_range(6))
      0: return '0;
      1: return DataW'(1);
      2: return m - 1;
      3: return m;
      4: return m + DataW'($urandom_range(100));
      5: return (m != '0) ? $urandom % m : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_modulus();
    case ($urandom_range(6))
      0: return DataW'(1);
      1: return DataW'(2);
      2: return AllOnes;
      3: return DataW'($urandom_range(5000, 3));
      4: return $urandom | {1'b1, {(DataW - 1){1'b0}}};
      default: return $urandom | DataW'(1);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] want, got);
    $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  task automatic send_operands(input logic [DataW-1:0] base, expo);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    base_value_i <= base;
    exponent_i <= expo;
    do @(posedge clk_i); while (!in_ready_o);
    power_q.push_back(modular_power(base, expo, modulus_now));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (power_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [DataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    modulus_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    modulus_now = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // modulus left at its reset value
  task automatic test_reset_modulus();
    send_operands('0, '0);
    send_operands(DataW'(5), '0);
    send_operands('0, DataW'(5));
    send_operands(DataW'(22), DataW'(1));
    send_operands(DataW'(23), DataW'(7));
    send_operands(AllOnes, AllOnes);
    send_operands(DataW'(2), DataW'(22));
    send_operands(DataW'(7), DataW'(32'h8000_0000));
    wait_all_results();
  endtask

  // modulus one: zero exponent still gives one
  task automatic test_unit_modulus();
    write_modulus(DataW'(1));
    send_operands(DataW'(5), '0);
    send_operands(DataW'(5), DataW'(1));
    send_operands(AllOnes, AllOnes);
    wait_all_results();
  endtask

  task automatic test_full_modulus();
    write_modulus(AllOnes);
    send_operands(AllOnes - 1, DataW'(2));
    send_operands(AllOnes, DataW'(3));
    send_operands(AllOnes - 1, AllOnes);
    send_operands(DataW'(32'h1234_5678), AllOnes - 1);
    send_operands(DataW'(3), DataW'(32'h8000_0001));
    wait_all_results();
  endtask

  task automatic test_modulus_two();
    write_modulus(DataW'(2));
    send_operands(DataW'(3), DataW'(5));
    send_operands(DataW'(4), DataW'(1));
    send_operands(AllOnes, '0);
    send_operands(AllOnes, AllOnes);
    wait_all_results();
  endtask

  task automatic test_random_operands(input int unsigned per_modulus, send_idle, recv_idle);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    for (int unsigned chunk = 0; chunk < 3; chunk++) begin
      write_modulus(rand_modulus());
      for (int unsigned n = 0; n < per_modulus; n++) begin
        send_operands(rand_base(modulus_now), rand_exponent());
      end
      wait_all_results();
    end
  endtask

  // results pile up while the receiver holds off, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_modulus(DataW'(32'hFFFF_FFFB));
    hold_left = 3000;
    for (int unsigned n = 0; n < 4; n++) begin
      send_operands($urandom, DataW'($urandom_range(255)));
    end
    wait_all_results();
  endtask

  always begin
    @(negedge clk_i);
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (power_q.size() == 0) begin
        report_mismatch("result with no transaction pending", '0, power_result_o);
      end else begin
        want_power = power_q.pop_front();
        if (power_result_o !== want_power) begin
          report_mismatch("power_result", want_power, power_result_o);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_modulus();
    test_unit_modulus();
    test_full_modulus();
    test_modulus_two();
    test_random_operands(30, 21, 83);
    test_random_operands(30, 83, 21);
    test_random_operands(30, 0, 0);
    test_backpressure();
    repeat (2500) @(posedge clk_i);
    if (error_count == 0 && power_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
sv/modexp_pkg.sv
sv/modexp_mul.sv
sv/modular_exponentiation_top.sv
sv/modexp_checker.sv
bench/modular_exponentiation_top_tb.sv
